FILE: hdl/lkpd_pkg.sv
// lkpd_pkg: shared types and constants for the ladder keypad press decoder
// button classes, event codes, fixed ladder windows and register map
// no dependencies

package lkpd_pkg;

    typedef logic [2:0] lkpd_class_t;
    typedef logic [3:0] lkpd_event_t;

    // button classes
    localparam lkpd_class_t CLS_IDLE  = 3'd0;
    localparam lkpd_class_t CLS_UP    = 3'd1;
    localparam lkpd_class_t CLS_DOWN  = 3'd2;
    localparam lkpd_class_t CLS_LEFT  = 3'd3;
    localparam lkpd_class_t CLS_RIGHT = 3'd4;

    // event codes
    localparam lkpd_event_t EV_NONE     = 4'd0;
    localparam lkpd_event_t LONG_OFFSET = 4'd4;

    // open windows on the ladder reading (bounds excluded)
    localparam logic [15:0] WIN_DOWN_LO  = 16'd170;
    localparam logic [15:0] WIN_DOWN_HI  = 16'd190;
    localparam logic [15:0] WIN_RIGHT_LO = 16'd311;
    localparam logic [15:0] WIN_RIGHT_HI = 16'd331;
    localparam logic [15:0] WIN_UP_LO    = 16'd600;
    localparam logic [15:0] WIN_UP_HI    = 16'd620;
    localparam logic [15:0] WIN_LEFT_LO  = 16'd830;
    localparam logic [15:0] WIN_LEFT_HI  = 16'd850;

    // register map, word index
    localparam int          ADDR_BITS       = 4;
    localparam logic [1:0]  REG_SHORT_PRESS = 2'd0;
    localparam logic [1:0]  REG_LONG_PRESS  = 2'd1;
    localparam logic [1:0]  REG_IDLE_REARM  = 2'd2;

    localparam logic [15:0] SHORT_PRESS_RST = 16'd10;
    localparam logic [15:0] LONG_PRESS_RST  = 16'd100;
    localparam logic [7:0]  IDLE_REARM_RST  = 8'd50;

    localparam logic [7:0]  IDLE_MAX = 8'hFF;

    function automatic lkpd_class_t classify(input logic [15:0] a);
        lkpd_class_t c;
        c = CLS_IDLE;
        if (a > WIN_DOWN_LO && a < WIN_DOWN_HI) begin
            c = CLS_DOWN;
        end else if (a > WIN_RIGHT_LO && a < WIN_RIGHT_HI) begin
            c = CLS_RIGHT;
        end else if (a > WIN_UP_LO && a < WIN_UP_HI) begin
            c = CLS_UP;
        end else if (a > WIN_LEFT_LO && a < WIN_LEFT_HI) begin
            c = CLS_LEFT;
        end
        return c;
    endfunction

endpackage

FILE: hdl/ladder_keypad_press_decoder.sv
// ladder_keypad_press_decoder: top level of the resistor ladder keypad decoder
// classifies ADC samples, tracks hold / idle time and emits press events
// depends on lkpd_pkg

// One ADC sample of the four-button ladder line enters per request on the s_
// stream and yields exactly one press event on the m_ stream, in order. Each
// sample is classified by fixed open windows (171..189 down, 312..330 right,
// 601..619 up, 831..849 left, anything else idle). A short press event (1 up,
// 2 down, 3 left, 4 right) is given once the same button has been seen for more
// than short_press_count consecutive repeats; a long event (5..8) follows once
// the hold passes long_press_count. Each fires once, until the line has been
// idle for more than idle_rearm_count samples; idle samples still move the
// fired flags (with a threshold of 0 a flag can be set on idle, with code 0).
// Classification, counter update and event decision are combinational up to the
// output register: an event is offered in the cycle after its sample is taken,
// and a sample is taken every cycle while that register is free or draining.
// Registers on the APB port: 0x0 short_press_count, 0x4 long_press_count,
// 0x8 idle_rearm_count; write them only while no request is in flight.

module ladder_keypad_press_decoder
    import lkpd_pkg::*;
#(
    parameter int SAMPLE_BITS     = 10,
    parameter int HOLD_COUNT_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    // sample stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [SAMPLE_BITS-1:0] ladder_sample

    // event stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [7:0]                             m_tdata,   // [3:0] press_event

    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ADDR_BITS-1:0]                   paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    // compare width covers both the hold counter and the 16-bit thresholds
    localparam int CMP_BITS = (HOLD_COUNT_BITS > 16) ? HOLD_COUNT_BITS : 16;

    // configuration registers
    logic [15:0] short_press_reg;
    logic [15:0] long_press_reg;
    logic [7:0]  idle_rearm_reg;

    // decoder state
    lkpd_class_t                last_class_reg, class_next;
    logic [HOLD_COUNT_BITS-1:0] hold_count_reg, hold_count_next;
    logic [7:0]                 idle_count_reg, idle_count_next;
    logic                       short_fired_reg, short_fired_next;
    logic                       long_fired_reg, long_fired_next;

    // output register
    logic        m_valid_reg;
    lkpd_event_t event_reg, event_next;

    logic in_fire;
    logic cfg_write;
    logic [1:0] cfg_index;

    logic rearm;
    logic fire_short;
    logic fire_long;
    logic short_flag_armed;
    logic long_flag_armed;
    logic [CMP_BITS-1:0] hold_cmp;

    // -------------------------------------------------------------------------
    // handshake: the output register takes a new event when empty or draining
    // -------------------------------------------------------------------------
    assign s_tready = ~m_valid_reg | m_tready;
    assign in_fire  = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, event_reg};

    // -------------------------------------------------------------------------
    // configuration port
    // -------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        unique case (cfg_index)
            REG_SHORT_PRESS: prdata = {16'd0, short_press_reg};
            REG_LONG_PRESS:  prdata = {16'd0, long_press_reg};
            REG_IDLE_REARM:  prdata = {24'd0, idle_rearm_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_press_reg <= SHORT_PRESS_RST;
            long_press_reg  <= LONG_PRESS_RST;
            idle_rearm_reg  <= IDLE_REARM_RST;
        end else if (cfg_write) begin
            // writes past the last register fall through and are dropped
            case (cfg_index)
                REG_SHORT_PRESS: short_press_reg <= pwdata[15:0];
                REG_LONG_PRESS:  long_press_reg  <= pwdata[15:0];
                REG_IDLE_REARM:  idle_rearm_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------------------
    // single pass: classify, count, decide
    // -------------------------------------------------------------------------
    always_comb begin
        // only the sample bits count; the windows are fixed
        class_next = classify(16'(s_tdata[SAMPLE_BITS-1:0]));

        // idle run length, saturating
        if (class_next == CLS_IDLE) begin
            idle_count_next = (idle_count_reg == IDLE_MAX) ? IDLE_MAX
                                                           : idle_count_reg + 8'd1;
        end else begin
            idle_count_next = 8'd0;
        end

        rearm = idle_count_next > idle_rearm_reg;

        // hold run length: an idle repeat restarts from zero then counts one
        if (class_next != last_class_reg) begin
            hold_count_next = '0;
        end else if (class_next == CLS_IDLE) begin
            hold_count_next = HOLD_COUNT_BITS'(1);
        end else if (hold_count_reg == '1) begin
            hold_count_next = hold_count_reg;
        end else begin
            hold_count_next = hold_count_reg + HOLD_COUNT_BITS'(1);
        end

        hold_cmp         = CMP_BITS'(hold_count_next);
        short_flag_armed = rearm | ~short_fired_reg;
        long_flag_armed  = rearm | ~long_fired_reg;

        // short check wins; long only when short did not fire
        fire_short = (hold_cmp > CMP_BITS'(short_press_reg)) & short_flag_armed;
        fire_long  = ~fire_short & (hold_cmp > CMP_BITS'(long_press_reg))
                     & long_flag_armed;

        short_fired_next = fire_short | (short_fired_reg & ~rearm);
        long_fired_next  = fire_long  | (long_fired_reg  & ~rearm);

        // flags move on idle too, but idle never reports an event
        if (class_next == CLS_IDLE) begin
            event_next = EV_NONE;
        end else if (fire_short) begin
            event_next = lkpd_event_t'(class_next);
        end else if (fire_long) begin
            event_next = lkpd_event_t'(class_next) + LONG_OFFSET;
        end else begin
            event_next = EV_NONE;
        end
    end

    // -------------------------------------------------------------------------
    // state and output registers
    // -------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_class_reg  <= CLS_IDLE;
            hold_count_reg  <= '0;
            idle_count_reg  <= 8'd0;
            short_fired_reg <= 1'b0;
            long_fired_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (in_fire) begin
                last_class_reg  <= class_next;
                hold_count_reg  <= hold_count_next;
                idle_count_reg  <= idle_count_next;
                short_fired_reg <= short_fired_next;
                long_fired_reg  <= long_fired_next;
                m_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    // event payload needs no reset
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            event_reg <= event_next;
        end
    end

endmodule

FILE: tb/lkpd_event_checker.sv
// lkpd_event_checker: watches the sample, event and apb channels of the keypad decoder
// keeps its own copy of thresholds and press state, predicts each event and compares it
// depends on lkpd_pkg
`timescale 1ns / 1ps

module lkpd_event_checker
    import lkpd_pkg::*;
#(
    parameter int SAMPLE_BITS     = 10,
    parameter int HOLD_COUNT_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [SAMPLE_BITS-1:0] ladder_sample
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [7:0]                              m_tdata,   // [3:0] press_event
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic                                    pready,
    input  logic [ADDR_BITS-1:0]                    paddr,
    input  logic [31:0]                             pwdata,
    output int                                      outstanding,
    output int                                      mismatches
);

    // thresholds as last written
    logic [15:0] short_limit;
    logic [15:0] long_limit;
    logic [7:0]  rearm_limit;

    // press tracking
    lkpd_class_t                prev_button;
    logic [HOLD_COUNT_BITS-1:0] hold_run;
    logic [7:0]                 idle_run;
    logic                       short_sent;
    logic                       long_sent;

    lkpd_event_t expected_events [$];
    int          err_cnt  = 0;
    int          n_events = 0;

    assign mismatches = err_cnt;

    function automatic lkpd_class_t button_of(input logic [SAMPLE_BITS-1:0] a);
        if (a > WIN_DOWN_LO && a < WIN_DOWN_HI) return CLS_DOWN;
        if (a > WIN_RIGHT_LO && a < WIN_RIGHT_HI) return CLS_RIGHT;
        if (a > WIN_UP_LO && a < WIN_UP_HI) return CLS_UP;
        if (a > WIN_LEFT_LO && a < WIN_LEFT_HI) return CLS_LEFT;
        return CLS_IDLE;
    endfunction

    // advances the press state by one sample and gives the event it causes
    function automatic lkpd_event_t next_press_event(input logic [SAMPLE_BITS-1:0] a);
        lkpd_class_t btn;
        logic        fire_short;
        logic        fire_long;
        lkpd_event_t ev;
        btn        = button_of(a);
        fire_short = 1'b0;
        fire_long  = 1'b0;
        ev         = EV_NONE;
        if (btn == CLS_IDLE) begin
            if (idle_run != IDLE_MAX) idle_run = idle_run + 8'd1;
            hold_run = '0;
        end else begin
            idle_run = '0;
        end
        if (idle_run > rearm_limit) begin
            short_sent = 1'b0;
            long_sent  = 1'b0;
        end
        if (prev_button != btn) begin
            hold_run = '0;
        end else if (hold_run != '1) begin
            hold_run = hold_run + 1'b1;
        end
        prev_button = btn;
        // flags move on idle too, only the code is suppressed
        if (hold_run > short_limit && !short_sent) begin
            short_sent = 1'b1;
            fire_short = 1'b1;
        end else if (hold_run > long_limit && !long_sent) begin
            long_sent = 1'b1;
            fire_long = 1'b1;
        end
        if (btn != CLS_IDLE) begin
            if (fire_short) ev = lkpd_event_t'(btn);
            else if (fire_long) ev = lkpd_event_t'(btn) + LONG_OFFSET;
        end
        return ev;
    endfunction

    always @(posedge aclk) begin : watch
        lkpd_event_t want;
        if (!aresetn) begin
            short_limit = SHORT_PRESS_RST;
            long_limit  = LONG_PRESS_RST;
            rearm_limit = IDLE_REARM_RST;
            prev_button = CLS_IDLE;
            hold_run    = '0;
            idle_run    = '0;
            short_sent  = 1'b0;
            long_sent   = 1'b0;
            expected_events.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    if (err_cnt < 10)
                        $display("%0t: press event %0d (code %0d) with no sample pending",
                                 $time, n_events, m_tdata[3:0]);
                    err_cnt++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_tdata[3:0] !== want) begin
                        if (err_cnt < 10)
                            $display("%0t: press event %0d: expected %0d, got %0d",
                                     $time, n_events, want, m_tdata[3:0]);
                        err_cnt++;
                    end
                end
                n_events++;
            end
            if (s_tvalid && s_tready)
                expected_events.push_back(next_press_event(s_tdata[SAMPLE_BITS-1:0]));
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SHORT_PRESS: short_limit = pwdata[15:0];
                    REG_LONG_PRESS:  long_limit  = pwdata[15:0];
                    REG_IDLE_REARM:  rearm_limit = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        outstanding <= expected_events.size();
    end

endmodule

FILE: tb/ladder_keypad_press_decoder_test.sv
// ladder_keypad_press_decoder_test: stimulus and verdict for the ladder keypad decoder
// drives samples and threshold writes, lets lkpd_event_checker predict and compare
// depends on lkpd_pkg, ladder_keypad_press_decoder and lkpd_event_checker
`timescale 1ns / 1ps

module ladder_keypad_press_decoder_test;
    import lkpd_pkg::*;

    localparam int SAMPLE_BITS     = 10;
    localparam int HOLD_COUNT_BITS = 16;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;

    // apb word index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall to back up the block
    localparam int DRAIN_LIMIT     = 5000;  // cycles to wait for outstanding events
    localparam int LATENCY_PAD     = 4;     // settle time after the last event
    localparam int PHASE_ITEMS     = 140;   // samples per random phase

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata  = '0;   // [9:0] ladder_sample

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;         // [3:0] press_event

    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_BITS-1:0]   paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int   outstanding;
    int   mismatches;

    // stimulus state; idling and hold_off_req are shared with the event receiver
    logic idling       = 1'b0;
    logic hold_off_req = 1'b0;
    logic stuck        = 1'b0;
    int   n_sent       = 0;

    always #1 aclk = ~aclk;

    ladder_keypad_press_decoder #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lkpd_event_checker #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // a random reading inside a button window, or anywhere outside all of them for idle
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input lkpd_class_t c);
        case (c)
            CLS_UP:    return SAMPLE_BITS'($urandom_range(WIN_UP_LO + 1, WIN_UP_HI - 1));
            CLS_DOWN:  return SAMPLE_BITS'($urandom_range(WIN_DOWN_LO + 1, WIN_DOWN_HI - 1));
            CLS_LEFT:  return SAMPLE_BITS'($urandom_range(WIN_LEFT_LO + 1, WIN_LEFT_HI - 1));
            CLS_RIGHT: return SAMPLE_BITS'($urandom_range(WIN_RIGHT_LO + 1, WIN_RIGHT_HI - 1));
            default: begin
                // the gaps between windows, bounds included
                case ($urandom_range(0, 4))
                    0:       return SAMPLE_BITS'($urandom_range(0, WIN_DOWN_LO));
                    1:       return SAMPLE_BITS'($urandom_range(WIN_DOWN_HI, WIN_RIGHT_LO));
                    2:       return SAMPLE_BITS'($urandom_range(WIN_RIGHT_HI, WIN_UP_LO));
                    3:       return SAMPLE_BITS'($urandom_range(WIN_UP_HI, WIN_LEFT_LO));
                    default: return SAMPLE_BITS'($urandom_range(WIN_LEFT_HI, SAMPLE_MAX));
                endcase
            end
        endcase
    endfunction

    // one sample request, with an optional gap in front while idling is on
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'(v);
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // stop offering and wait until every predicted event has come back, or the wait limit runs out
    task automatic drain_events();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        if (outstanding != 0) stuck = 1'b1;
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    // setup cycle then access cycle, pready is always high
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [15:0] short_cnt, input logic [15:0] long_cnt,
                                  input logic [7:0] rearm_cnt);
        cfg_write(REG_SHORT_PRESS, short_cnt);
        cfg_write(REG_LONG_PRESS, long_cnt);
        cfg_write(REG_IDLE_REARM, {8'd0, rearm_cnt});
    endtask

    // mostly clean presses followed by idle, plus idle runs, noise and button swaps
    task automatic run_presses(input int count);
        int          target;
        int          kind;
        int          len;
        lkpd_class_t c;
        lkpd_class_t d;
        target = n_sent + count;
        while (n_sent < target) begin
            kind = $urandom_range(0, 9);
            c    = lkpd_class_t'($urandom_range(CLS_UP, CLS_RIGHT));
            if (kind < 6) begin
                // press and release, now and then long enough for the default long count
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 130)
                                                  : $urandom_range(1, 12);
                repeat (len) send_sample(pick_sample(c));
                repeat ($urandom_range(1, 12)) send_sample(pick_sample(CLS_IDLE));
            end else if (kind < 8) begin
                // idle stretch, sometimes past the rearm count
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 70)
                                                  : $urandom_range(1, 12);
                repeat (len) send_sample(pick_sample(CLS_IDLE));
            end else if (kind == 8) begin
                // raw noise over the whole adc range
                repeat ($urandom_range(1, 4))
                    send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
            end else begin
                // one button slides into another with no release in between
                d = c;
                while (d == c) d = lkpd_class_t'($urandom_range(CLS_UP, CLS_RIGHT));
                repeat ($urandom_range(1, 6)) send_sample(pick_sample(c));
                repeat ($urandom_range(1, 6)) send_sample(pick_sample(d));
            end
        end
    endtask

    // event receiver: random stalls while idling is on, one long hold-off on request
    initial begin : event_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_tready <= 1'b1;
            end else if (idling && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                run_left = $urandom_range(0, 9);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [SAMPLE_BITS-1:0] edge_samples [24];
        int                     phase;
        // window bounds, adc extremes, and three samples per button; as idle samples
        // set the short flag, a zero threshold gives nothing, then long, then nothing
        edge_samples = '{10'd0,   10'd1023, 10'd170, 10'd171, 10'd189, 10'd172,
                         10'd190, 10'd311,  10'd312, 10'd330, 10'd321, 10'd331,
                         10'd600, 10'd601,  10'd619, 10'd610, 10'd620, 10'd830,
                         10'd831, 10'd849,  10'd840, 10'd850, 10'd0,   10'd1023};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // zero thresholds: idle samples set the short flag, since short comes before long
        set_thresholds(16'd0, 16'd0, 8'd0);
        cfg_write(REG_UNUSED, 16'hFFFF);
        foreach (edge_samples[i]) send_sample(edge_samples[i]);
        drain_events();

        // rearm at 255 never clears, since the idle counter stops there
        set_thresholds(16'd2, 16'd5, 8'd255);
        repeat (8) send_sample(pick_sample(CLS_UP));
        repeat (300) send_sample(pick_sample(CLS_IDLE));
        repeat (8) send_sample(pick_sample(CLS_UP));
        repeat (260) send_sample(pick_sample(CLS_IDLE));
        drain_events();
        // idle counter sits at its top, one more idle sample now rearms
        cfg_write(REG_IDLE_REARM, 16'd254);
        send_sample(pick_sample(CLS_IDLE));
        repeat (8) send_sample(pick_sample(CLS_LEFT));
        drain_events();

        // random phases, extremes first, the last two without idling
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       set_thresholds(16'd0, 16'd0, 8'd0);
                1:       set_thresholds(16'hFFFF, 16'hFFFF, 8'hFF);
                2:       set_thresholds(SHORT_PRESS_RST, LONG_PRESS_RST, IDLE_REARM_RST);
                default: set_thresholds(16'($urandom_range(0, 6)), 16'($urandom_range(0, 24)),
                                        8'($urandom_range(0, 12)));
            endcase
            idling = (phase == 0 || phase == 1 || phase == 3 || phase == 4 || phase == 5);
            if (phase == 3) begin
                // block the receiver while samples keep coming
                run_presses(60);
                hold_off_req = 1'b1;
                run_presses(PHASE_ITEMS - 60);
            end else begin
                run_presses(PHASE_ITEMS);
            end
            drain_events();
        end

        if (!stuck && mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
